// ===== design/l63_pkg.sv =====
// Shared types, codes, constants and the microprogram of the Lorenz-63 Heun step unit.
package l63_pkg;

    // Fixed formats of the datapath.
    localparam int DATA_W = 32;   // Q12.20 state and result values
    localparam int WIDE_W = 33;   // exact corrector sum and operand bus
    localparam int COEF_W = 31;   // unsigned Q11.20 coefficients
    localparam int DT_W   = 24;   // unsigned Q0.24 time step
    localparam int PROD_W = 66;   // full product of two operand-bus values

    // Coefficient values after reset.
    localparam logic [COEF_W-1:0] SIGMA_RST = 31'd10485760;
    localparam logic [COEF_W-1:0] BETA_RST  = 31'd2796203;
    localparam logic [COEF_W-1:0] RHO_RST   = 31'd29360128;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIGMA = 2'd0;
    localparam logic [1:0] CFG_BETA  = 2'd1;
    localparam logic [1:0] CFG_RHO   = 2'd2;

    // Operations of the shared arithmetic unit.
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_ADDW  = 3'd3;
    localparam logic [2:0] OP_MUL20 = 3'd4;
    localparam logic [2:0] OP_MUL24 = 3'd5;
    localparam logic [2:0] OP_MUL25 = 3'd6;

    // Operand and destination register codes.
    localparam logic [4:0] R_SX  = 5'd0;
    localparam logic [4:0] R_SY  = 5'd1;
    localparam logic [4:0] R_SZ  = 5'd2;
    localparam logic [4:0] R_PX  = 5'd3;
    localparam logic [4:0] R_PY  = 5'd4;
    localparam logic [4:0] R_PZ  = 5'd5;
    localparam logic [4:0] R_AX  = 5'd6;
    localparam logic [4:0] R_AY  = 5'd7;
    localparam logic [4:0] R_AZ  = 5'd8;
    localparam logic [4:0] R_CX  = 5'd9;
    localparam logic [4:0] R_CY  = 5'd10;
    localparam logic [4:0] R_CZ  = 5'd11;
    localparam logic [4:0] R_T0  = 5'd12;
    localparam logic [4:0] R_T1  = 5'd13;
    localparam logic [4:0] R_T2  = 5'd14;
    localparam logic [4:0] R_T3  = 5'd15;
    localparam logic [4:0] R_W0  = 5'd16;
    localparam logic [4:0] R_W1  = 5'd17;
    localparam logic [4:0] R_W2  = 5'd18;
    localparam logic [4:0] R_SIG = 5'd19;
    localparam logic [4:0] R_BET = 5'd20;
    localparam logic [4:0] R_RHO = 5'd21;
    localparam logic [4:0] R_DT  = 5'd22;
    localparam logic [4:0] R_NX  = 5'd23;
    localparam logic [4:0] R_NY  = 5'd24;
    localparam logic [4:0] R_NZ  = 5'd25;

    localparam logic [5:0] PC_LAST = 6'd33;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] dst;
        logic [4:0] src_a;
        logic [4:0] src_b;
    } instr_t;

    typedef struct packed {
        logic               en;
        logic [4:0]         dst;
        logic signed [32:0] val;
        logic               ovf;
    } wb_t;

    typedef struct packed {
        logic   idle;
        logic   out_load;
        instr_t instr;
    } seq_ctl_t;

    function automatic instr_t mk(input logic [2:0] op, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b);
        instr_t r;
        r.op    = op;
        r.dst   = dst;
        r.src_a = a;
        r.src_b = b;
        return r;
    endfunction

    // One Heun step. A result is visible to instructions issued two or more
    // slots after its producer; the order below keeps that distance.
    function automatic instr_t prog_rom(input logic [5:0] pc);
        instr_t r;
        case (pc)
            // Derivative at the current state into A.
            6'd0:  r = mk(OP_SUB,   R_T0, R_SY,  R_SX);
            6'd1:  r = mk(OP_SUB,   R_T1, R_RHO, R_SZ);
            6'd2:  r = mk(OP_MUL20, R_T2, R_SX,  R_SY);
            6'd3:  r = mk(OP_MUL20, R_T3, R_BET, R_SZ);
            6'd4:  r = mk(OP_MUL20, R_AX, R_SIG, R_T0);
            6'd5:  r = mk(OP_MUL20, R_T1, R_SX,  R_T1);
            6'd6:  r = mk(OP_SUB,   R_AZ, R_T2,  R_T3);
            6'd7:  r = mk(OP_SUB,   R_AY, R_T1,  R_SY);
            // Euler predictor into P.
            6'd8:  r = mk(OP_MUL24, R_T0, R_DT,  R_AX);
            6'd9:  r = mk(OP_MUL24, R_T2, R_DT,  R_AY);
            6'd10: r = mk(OP_MUL24, R_T3, R_DT,  R_AZ);
            6'd11: r = mk(OP_ADD,   R_PX, R_SX,  R_T0);
            6'd12: r = mk(OP_ADD,   R_PY, R_SY,  R_T2);
            6'd13: r = mk(OP_ADD,   R_PZ, R_SZ,  R_T3);
            // Derivative at the predictor into C.
            6'd14: r = mk(OP_SUB,   R_T0, R_PY,  R_PX);
            6'd15: r = mk(OP_SUB,   R_T1, R_RHO, R_PZ);
            6'd16: r = mk(OP_MUL20, R_T2, R_PX,  R_PY);
            6'd17: r = mk(OP_MUL20, R_T3, R_BET, R_PZ);
            6'd18: r = mk(OP_MUL20, R_CX, R_SIG, R_T0);
            6'd19: r = mk(OP_MUL20, R_T1, R_PX,  R_T1);
            6'd20: r = mk(OP_SUB,   R_CZ, R_T2,  R_T3);
            6'd21: r = mk(OP_SUB,   R_CY, R_T1,  R_PY);
            // Corrector and noise.
            6'd22: r = mk(OP_ADDW,  R_W0, R_AX,  R_CX);
            6'd23: r = mk(OP_ADDW,  R_W1, R_AY,  R_CY);
            6'd24: r = mk(OP_ADDW,  R_W2, R_AZ,  R_CZ);
            6'd25: r = mk(OP_MUL25, R_T0, R_DT,  R_W0);
            6'd26: r = mk(OP_MUL25, R_T1, R_DT,  R_W1);
            6'd27: r = mk(OP_MUL25, R_T2, R_DT,  R_W2);
            6'd28: r = mk(OP_ADD,   R_T0, R_SX,  R_T0);
            6'd29: r = mk(OP_ADD,   R_T1, R_SY,  R_T1);
            6'd30: r = mk(OP_ADD,   R_T2, R_SZ,  R_T2);
            6'd31: r = mk(OP_ADD,   R_SX, R_T0,  R_NX);
            6'd32: r = mk(OP_ADD,   R_SY, R_T1,  R_NY);
            6'd33: r = mk(OP_ADD,   R_SZ, R_T2,  R_NZ);
            default: r = mk(OP_NOP, R_T0, R_T0,  R_T0);
        endcase
        return r;
    endfunction

endpackage

// ===== design/l63_alu.sv =====
// Shared two-stage arithmetic unit: multiply or add, then round, shift and saturate.
module l63_alu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           op,
    input  logic [4:0]           dst,
    input  logic signed [32:0]   opa,
    input  logic signed [32:0]   opb,
    output l63_pkg::wb_t         wb
);
    import l63_pkg::*;

    localparam logic signed [PROD_W-1:0] RND20  = 66'sd524288;
    localparam logic signed [PROD_W-1:0] RND24  = 66'sd8388608;
    localparam logic signed [PROD_W-1:0] RND25  = 66'sd16777216;
    localparam logic signed [PROD_W-1:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_LO = -66'sd2147483648;

    logic signed [PROD_W-1:0] prod;
    logic signed [33:0]       sum_v;
    logic signed [PROD_W-1:0] val_next;
    logic signed [PROD_W-1:0] val_reg;
    logic [2:0]               op_reg;
    logic [4:0]               dst_reg;
    logic                     vld_reg;
    logic signed [PROD_W-1:0] rnd;

    // Stage one: the multiplier or the adder.
    assign prod = opa * opb;

    always_comb begin
        sum_v = 34'(opa) + 34'(opb);
        if (op == OP_SUB) begin
            sum_v = 34'(opa) - 34'(opb);
        end
        case (op)
            OP_MUL20, OP_MUL24, OP_MUL25: val_next = prod;
            default:                      val_next = PROD_W'(sum_v);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= (op != OP_NOP);
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op;
        dst_reg <= dst;
        val_reg <= val_next;
    end

    // Stage two: round half up, drop the fraction, clamp all but ADDW to 32 bits.
    always_comb begin
        case (op_reg)
            OP_MUL20: rnd = (val_reg + RND20) >>> 20;
            OP_MUL24: rnd = (val_reg + RND24) >>> 24;
            OP_MUL25: rnd = (val_reg + RND25) >>> 25;
            default:  rnd = val_reg;
        endcase
        wb.en  = vld_reg;
        wb.dst = dst_reg;
        wb.ovf = 1'b0;
        wb.val = rnd[32:0];
        if (op_reg != OP_ADDW) begin
            if (rnd > SAT_HI) begin
                wb.val = SAT_HI[32:0];
                wb.ovf = vld_reg;
            end else if (rnd < SAT_LO) begin
                wb.val = SAT_LO[32:0];
                wb.ovf = vld_reg;
            end
        end
    end

endmodule

// ===== design/l63_seq.sv =====
// Sequencer that steps the microprogram through the shared arithmetic unit.
module l63_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_step,
    input  logic              start_load,
    input  logic              out_free,
    output l63_pkg::seq_ctl_t ctl
);
    import l63_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [5:0] pc_reg;
    logic [5:0] pc_next;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE: begin
                pc_next = 6'd0;
                if (start_step) begin
                    state_next = ST_RUN;
                end else if (start_load) begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN: begin
                pc_next = pc_reg + 6'd1;
                if (pc_reg == PC_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last writeback lands at the end of this cycle.
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= 6'd0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb begin
        ctl.idle     = (state_reg == ST_IDLE);
        ctl.out_load = (state_reg == ST_DONE) && out_free;
        ctl.instr    = prog_rom(pc_reg);
        if (state_reg != ST_RUN) begin
            ctl.instr.op = OP_NOP;
        end
    end

endmodule

// ===== design/lorenz63_heun_step_unit.sv =====
// Top level of the Lorenz-63 Heun step unit: state, operand selection, config and output.
//
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_req_type, s_dt, s_noise_*, s_init_*
// m_        out        m_valid / m_ready    m_out_x, m_out_y, m_out_z, m_overflow
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A step transaction runs from acceptance until m_valid rises: the
// sequencer issues 34 instructions, one per cycle, into the single shared
// multiply/add unit, waits in its drain state for the last writeback of its
// second stage, and loads the output register from its done state; a new step
// can be accepted once the sequencer is idle again. A load transaction goes
// straight to the done state after acceptance. s_ready is high only while the
// sequencer is idle; a result waits in the output register, and the sequencer
// holds the next result until that register is free. Reset is synchronous and
// active low; it clears the state to zero and restores the default coefficients.
module lorenz63_heun_step_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [23:0]        s_dt,
    input  logic signed [31:0] s_noise_x,
    input  logic signed [31:0] s_noise_y,
    input  logic signed [31:0] s_noise_z,
    input  logic signed [31:0] s_init_x,
    input  logic signed [31:0] s_init_y,
    input  logic signed [31:0] s_init_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic               m_overflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import l63_pkg::*;

    // All values the microprogram can name as operands, gathered for selection.
    typedef struct packed {
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] ax, ay, az;
        logic signed [31:0] cx, cy, cz;
        logic signed [31:0] t0, t1, t2, t3;
        logic signed [32:0] w0, w1, w2;
        logic [30:0]        sig, bet, rho;
        logic [23:0]        dt;
        logic signed [31:0] nx, ny, nz;
    } bank_t;

    function automatic logic signed [32:0] pick(input logic [4:0] code, input bank_t bk);
        logic signed [32:0] v;
        case (code)
            R_SX:  v = 33'(bk.sx);
            R_SY:  v = 33'(bk.sy);
            R_SZ:  v = 33'(bk.sz);
            R_PX:  v = 33'(bk.px);
            R_PY:  v = 33'(bk.py);
            R_PZ:  v = 33'(bk.pz);
            R_AX:  v = 33'(bk.ax);
            R_AY:  v = 33'(bk.ay);
            R_AZ:  v = 33'(bk.az);
            R_CX:  v = 33'(bk.cx);
            R_CY:  v = 33'(bk.cy);
            R_CZ:  v = 33'(bk.cz);
            R_T0:  v = 33'(bk.t0);
            R_T1:  v = 33'(bk.t1);
            R_T2:  v = 33'(bk.t2);
            R_T3:  v = 33'(bk.t3);
            R_W0:  v = bk.w0;
            R_W1:  v = bk.w1;
            R_W2:  v = bk.w2;
            R_SIG: v = {2'b00, bk.sig};
            R_BET: v = {2'b00, bk.bet};
            R_RHO: v = {2'b00, bk.rho};
            R_DT:  v = {9'd0, bk.dt};
            R_NX:  v = 33'(bk.nx);
            R_NY:  v = 33'(bk.ny);
            R_NZ:  v = 33'(bk.nz);
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // Architectural state and coefficients.
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [30:0]        sigma_reg, beta_reg, rho_reg;
    logic               ovf_reg;

    // Working registers of one step; they need no reset.
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [32:0] w0_reg, w1_reg, w2_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;

    // Output register.
    logic               m_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               out_ovf_reg;

    logic               s_fire;
    logic               start_step;
    logic               start_load;
    logic               out_free;
    seq_ctl_t           ctl;
    wb_t                wb;
    bank_t              bank;
    logic signed [32:0] opa;
    logic signed [32:0] opb;

    assign s_ready    = ctl.idle;
    assign s_fire     = s_valid && s_ready;
    assign start_step = s_fire && !s_req_type;
    assign start_load = s_fire && s_req_type;
    assign out_free   = !m_valid_reg || m_ready;
    assign cfg_ready  = 1'b1;

    l63_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_step (start_step),
        .start_load (start_load),
        .out_free   (out_free),
        .ctl        (ctl)
    );

    always_comb begin
        bank.sx  = pos_x_reg;
        bank.sy  = pos_y_reg;
        bank.sz  = pos_z_reg;
        bank.px  = px_reg;
        bank.py  = py_reg;
        bank.pz  = pz_reg;
        bank.ax  = ax_reg;
        bank.ay  = ay_reg;
        bank.az  = az_reg;
        bank.cx  = cx_reg;
        bank.cy  = cy_reg;
        bank.cz  = cz_reg;
        bank.t0  = t0_reg;
        bank.t1  = t1_reg;
        bank.t2  = t2_reg;
        bank.t3  = t3_reg;
        bank.w0  = w0_reg;
        bank.w1  = w1_reg;
        bank.w2  = w2_reg;
        bank.sig = sigma_reg;
        bank.bet = beta_reg;
        bank.rho = rho_reg;
        bank.dt  = dt_reg;
        bank.nx  = nx_reg;
        bank.ny  = ny_reg;
        bank.nz  = nz_reg;
        opa = pick(ctl.instr.src_a, bank);
        opb = pick(ctl.instr.src_b, bank);
    end

    l63_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (ctl.instr.op),
        .dst     (ctl.instr.dst),
        .opa     (opa),
        .opb     (opb),
        .wb      (wb)
    );

    // State, coefficients and the sticky saturation flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= 32'sd0;
            pos_y_reg <= 32'sd0;
            pos_z_reg <= 32'sd0;
            sigma_reg <= SIGMA_RST;
            beta_reg  <= BETA_RST;
            rho_reg   <= RHO_RST;
            ovf_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SIGMA: sigma_reg <= cfg_data[30:0];
                    CFG_BETA:  beta_reg  <= cfg_data[30:0];
                    CFG_RHO:   rho_reg   <= cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            if (start_load) begin
                pos_x_reg <= s_init_x;
                pos_y_reg <= s_init_y;
                pos_z_reg <= s_init_z;
            end
            if (wb.en) begin
                case (wb.dst)
                    R_SX: pos_x_reg <= wb.val[31:0];
                    R_SY: pos_y_reg <= wb.val[31:0];
                    R_SZ: pos_z_reg <= wb.val[31:0];
                    default: begin
                    end
                endcase
            end
            if (s_fire) begin
                ovf_reg <= 1'b0;
            end else if (wb.en && wb.ovf) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Per-step inputs and intermediate values.
    always_ff @(posedge aclk) begin
        if (start_step) begin
            dt_reg <= s_dt;
            nx_reg <= s_noise_x;
            ny_reg <= s_noise_y;
            nz_reg <= s_noise_z;
        end
        if (wb.en) begin
            case (wb.dst)
                R_PX: px_reg <= wb.val[31:0];
                R_PY: py_reg <= wb.val[31:0];
                R_PZ: pz_reg <= wb.val[31:0];
                R_AX: ax_reg <= wb.val[31:0];
                R_AY: ay_reg <= wb.val[31:0];
                R_AZ: az_reg <= wb.val[31:0];
                R_CX: cx_reg <= wb.val[31:0];
                R_CY: cy_reg <= wb.val[31:0];
                R_CZ: cz_reg <= wb.val[31:0];
                R_T0: t0_reg <= wb.val[31:0];
                R_T1: t1_reg <= wb.val[31:0];
                R_T2: t2_reg <= wb.val[31:0];
                R_T3: t3_reg <= wb.val[31:0];
                R_W0: w0_reg <= wb.val;
                R_W1: w1_reg <= wb.val;
                R_W2: w2_reg <= wb.val;
                default: begin
                end
            endcase
        end
    end

    // Output register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_x_reg   <= pos_x_reg;
            out_y_reg   <= pos_y_reg;
            out_z_reg   <= pos_z_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_x    = out_x_reg;
    assign m_out_y    = out_y_reg;
    assign m_out_z    = out_z_reg;
    assign m_overflow = out_ovf_reg;

endmodule

// ===== design/l63_checker.sv =====
// Port-level checks of the Lorenz-63 Heun step unit and their binding to the top level.
module l63_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_out_x,
    input logic signed [31:0] m_out_y,
    input logic signed [31:0] m_out_z,
    input logic               m_overflow,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Only one transaction is in work at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while busy");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
        && $stable(m_out_z) && $stable(m_overflow))
        else $error("stalled result changed");

    // Configuration writes are never held off.
    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind lorenz63_heun_step_unit l63_checker u_l63_checker (.*);
